// ===== rtl/core/ctd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar time difference package
// Shared constants, control types and calendar helper functions.
// ----------------------------------------------------------------------------
package ctd_pkg;

    // Largest year span that is still a valid item.
    localparam int unsigned MAX_YEAR_SPAN = 20;
    localparam int unsigned YEAR_CNT_W    = $clog2(MAX_YEAR_SPAN + 1);

    // Accumulator holds a sign bit above the 32-bit result.
    localparam int unsigned ACC_W = 33;
    localparam int unsigned OPD_W = 32;

    localparam logic [OPD_W-1:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [OPD_W-1:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [OPD_W-1:0] SECS_PER_MIN  = 32'd60;
    localparam logic [OPD_W-1:0] SECS_PER_YEAR = 32'd31536000;
    localparam logic [3:0]       MONTHS_PER_YEAR = 4'd12;

    // Seconds from the start of the year to the start of each month.
    localparam logic [OPD_W-1:0] MONTH_START [12] = '{
        32'd0,        32'd2678400,  32'd5097600,  32'd7776000,
        32'd10368000, 32'd13046400, 32'd15638400, 32'd18316800,
        32'd20995200, 32'd23587200, 32'd26265600, 32'd28857600
    };

    // Term codes: the parts of a seconds-into-year value, one per step.
    localparam logic [2:0] TERM_MONTH = 3'd0;
    localparam logic [2:0] TERM_DAY   = 3'd1;
    localparam logic [2:0] TERM_HOUR  = 3'd2;
    localparam logic [2:0] TERM_MIN   = 3'd3;
    localparam logic [2:0] TERM_SEC   = 3'd4;

    // Control of the shared accumulate unit.
    typedef struct packed {
        logic clear;
        logic en;
        logic sub;
    } t_acc_ctl;

    // Month field to table index; zero maps to January, above 12 to December.
    function automatic logic [3:0] month_idx(input logic [3:0] mo);
        logic [3:0] v;
        if (mo == 4'd0) begin
            v = 4'd0;
        end else if (mo > MONTHS_PER_YEAR) begin
            v = MONTHS_PER_YEAR - 4'd1;
        end else begin
            v = mo - 4'd1;
        end
        return v;
    endfunction

    // One term of the seconds-into-year value of a timestamp.
    function automatic logic [OPD_W-1:0] term_value(
        input logic [2:0] sel,
        input logic [5:0] sec,
        input logic [5:0] mnt,
        input logic [4:0] hr,
        input logic [4:0] dy,
        input logic [3:0] mo
    );
        logic [OPD_W-1:0] v;
        logic [4:0]       dz;
        dz = (dy == 5'd0) ? 5'd0 : dy - 5'd1;
        case (sel)
            TERM_MONTH: v = MONTH_START[month_idx(mo)];
            TERM_DAY:   v = OPD_W'(dz) * SECS_PER_DAY;
            TERM_HOUR:  v = OPD_W'(hr) * SECS_PER_HOUR;
            TERM_MIN:   v = OPD_W'(mnt) * SECS_PER_MIN;
            TERM_SEC:   v = OPD_W'(sec);
            default:    v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ctd_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared accumulate unit
// One add/subtract unit with its accumulator register, reused for every year and every term.
// ----------------------------------------------------------------------------
module ctd_accum (
    input  wire logic                      i_clk,
    input  wire ctd_pkg::t_acc_ctl         i_ctl,
    input  wire logic [ctd_pkg::OPD_W-1:0] i_operand,
    output logic [ctd_pkg::ACC_W-1:0]      o_acc
);
    import ctd_pkg::*;

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;
    logic [ACC_W-1:0] w_opd;

    assign w_opd = {1'b0, i_operand};

    // Add or subtract the operand; clear starts a new item.
    always_comb begin
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.en) begin
            n_acc = i_ctl.sub ? (r_acc - w_opd) : (r_acc + w_opd);
        end else begin
            n_acc = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire

// ===== rtl/core/calendar_time_difference.sv =====
`timescale 1ns / 1ps
`default_nettype none
// After accepting an item the sequencer adds one year per year of span (0 to 20), then
// the month, day, hour, minute and second terms of now and of then, and registers the
// result with its strobe; an item with a bad year order or span skips to the final step.
// One item at a time, busy until the result strobe; the single shared adder adds one year
// or one term per cycle. Reset is synchronous and active low; the receiver cannot stall the result.
// ----------------------------------------------------------------------------
// Calendar time difference
// Elapsed seconds between two timestamps of a calendar without leap years.
// ----------------------------------------------------------------------------
module calendar_time_difference (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [5:0]  i_then_second,
    input  wire logic [5:0]  i_then_minute,
    input  wire logic [4:0]  i_then_hour,
    input  wire logic [4:0]  i_then_day,
    input  wire logic [3:0]  i_then_month,
    input  wire logic [15:0] i_then_year,
    input  wire logic [5:0]  i_now_second,
    input  wire logic [5:0]  i_now_minute,
    input  wire logic [4:0]  i_now_hour,
    input  wire logic [4:0]  i_now_day,
    input  wire logic [3:0]  i_now_month,
    input  wire logic [15:0] i_now_year,
    output logic             o_done,
    output logic [31:0]      o_elapsed_seconds,
    output logic             o_span_error
);
    import ctd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_YEARS = 4'b0010,
        S_TERMS = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Captured item.
    logic [5:0] r_then_sec, r_then_min, r_now_sec, r_now_min;
    logic [4:0] r_then_hr, r_then_day, r_now_hr, r_now_day;
    logic [3:0] r_then_mon, r_now_mon;

    logic [YEAR_CNT_W-1:0] r_yr_cnt, n_yr_cnt;
    logic                  r_yr_err, n_yr_err;
    logic [2:0]            r_term, n_term;
    logic                  r_side, n_side;

    logic        r_done, n_done;
    logic [31:0] r_elapsed, n_elapsed;
    logic        r_err, n_err;

    logic              w_accept;
    logic [16:0]       w_year_diff;
    logic              w_year_bad;
    t_acc_ctl          w_ctl;
    logic [OPD_W-1:0]  w_operand;
    logic [OPD_W-1:0]  w_term;
    logic [ACC_W-1:0]  w_acc;
    logic              w_fin_err;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    // Year order and span check on the incoming item.
    assign w_year_diff = {1'b0, i_now_year} - {1'b0, i_then_year};
    assign w_year_bad  = w_year_diff[16] || (w_year_diff[15:0] > 16'(MAX_YEAR_SPAN));

    // Term of now (added) or of then (subtracted).
    always_comb begin
        if (r_side) begin
            w_term = term_value(r_term, r_then_sec, r_then_min, r_then_hr,
                                r_then_day, r_then_mon);
        end else begin
            w_term = term_value(r_term, r_now_sec, r_now_min, r_now_hr,
                                r_now_day, r_now_mon);
        end
    end

    assign w_operand = (r_state == S_YEARS) ? SECS_PER_YEAR : w_term;

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_yr_cnt  = r_yr_cnt;
        n_yr_err  = r_yr_err;
        n_term    = r_term;
        n_side    = r_side;
        n_done    = 1'b0;
        n_elapsed = r_elapsed;
        n_err     = r_err;
        w_ctl     = '{clear: 1'b0, en: 1'b0, sub: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_ctl.clear = 1'b1;
                    n_yr_err    = w_year_bad;
                    n_yr_cnt    = w_year_diff[YEAR_CNT_W-1:0];
                    n_term      = TERM_MONTH;
                    n_side      = 1'b0;
                    n_state     = w_year_bad ? S_FIN : S_YEARS;
                end
            end
            S_YEARS: begin
                if (r_yr_cnt == '0) begin
                    n_state = S_TERMS;
                end else begin
                    w_ctl.en = 1'b1;
                    n_yr_cnt = r_yr_cnt - YEAR_CNT_W'(1);
                end
            end
            S_TERMS: begin
                w_ctl.en  = 1'b1;
                w_ctl.sub = r_side;
                if (r_term == TERM_SEC) begin
                    n_term = TERM_MONTH;
                    n_side = 1'b1;
                    if (r_side) begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_term = r_term + 3'd1;
                end
            end
            S_FIN: begin
                n_done    = 1'b1;
                n_err     = w_fin_err;
                n_elapsed = w_fin_err ? 32'd0 : w_acc[31:0];
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A negative accumulator means now precedes then.
    assign w_fin_err = r_yr_err || w_acc[ACC_W-1];

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_yr_cnt  <= n_yr_cnt;
        r_yr_err  <= n_yr_err;
        r_term    <= n_term;
        r_side    <= n_side;
        r_elapsed <= n_elapsed;
        r_err     <= n_err;
        if (w_accept) begin
            r_then_sec <= i_then_second;
            r_then_min <= i_then_minute;
            r_then_hr  <= i_then_hour;
            r_then_day <= i_then_day;
            r_then_mon <= i_then_month;
            r_now_sec  <= i_now_second;
            r_now_min  <= i_now_minute;
            r_now_hr   <= i_now_hour;
            r_now_day  <= i_now_day;
            r_now_mon  <= i_now_month;
        end
    end

    ctd_accum u_accum (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_operand (w_operand),
        .o_acc     (w_acc)
    );

    assign o_done            = r_done;
    assign o_elapsed_seconds = r_elapsed;
    assign o_span_error      = r_err;

    // The strobe rises in the cycle after the final step.
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> o_done)
        else $error("result strobe missing after final step");

    // An error result always carries zero seconds.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_span_error) |-> (o_elapsed_seconds == 32'd0))
        else $error("error result with nonzero seconds");

    // An accepted item makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("block not busy after accepting an item");

    // One strobe per item.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

endmodule
`default_nettype wire

// ===== dv/calendar_time_difference_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar time difference checker
// Watches the command and result channels of the block. It works out the
// elapsed seconds and span flag for every accepted item, queues them in
// order, and compares each result strobe with the oldest pending one.
// ----------------------------------------------------------------------------
module calendar_time_difference_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [5:0]  i_then_second,
    input  wire logic [5:0]  i_then_minute,
    input  wire logic [4:0]  i_then_hour,
    input  wire logic [4:0]  i_then_day,
    input  wire logic [3:0]  i_then_month,
    input  wire logic [15:0] i_then_year,
    input  wire logic [5:0]  i_now_second,
    input  wire logic [5:0]  i_now_minute,
    input  wire logic [4:0]  i_now_hour,
    input  wire logic [4:0]  i_now_day,
    input  wire logic [3:0]  i_now_month,
    input  wire logic [15:0] i_now_year,
    input  wire logic        o_done,
    input  wire logic [31:0] o_elapsed_seconds,
    input  wire logic        o_span_error,
    output int               fail_count,
    output int               pending_spans
);
    import ctd_pkg::*;

    typedef struct {
        logic [31:0] seconds;
        logic        flag;
    } span_t;

    span_t expected_spans [$];

    // Offset of a month from the start of the year; out-of-range months clamp.
    function automatic logic [63:0] month_offset(input logic [3:0] mo);
        int idx;
        if (mo == 4'd0) begin
            idx = 0;
        end else if (mo > 4'd12) begin
            idx = 11;
        end else begin
            idx = int'(mo) - 1;
        end
        return 64'(MONTH_START[idx]);
    endfunction

    // Seconds into the month; a day of zero counts as the first day.
    function automatic logic [63:0] secs_into_month(
        input logic [5:0] s,
        input logic [5:0] m,
        input logic [4:0] h,
        input logic [4:0] d
    );
        logic [63:0] day0;
        day0 = (d == 5'd0) ? 64'd0 : 64'(d) - 64'd1;
        return day0 * 64'd86400 + 64'(h) * 64'd3600 + 64'(m) * 64'd60 + 64'(s);
    endfunction

    // Elapsed seconds from then to now, with the flag for bad spans.
    function automatic span_t elapsed_between(
        input logic [5:0] ts, input logic [5:0] tm, input logic [4:0] th,
        input logic [4:0] td, input logic [3:0] tmo, input logic [15:0] ty,
        input logic [5:0] ns, input logic [5:0] nm, input logic [4:0] nh,
        input logic [4:0] nd, input logic [3:0] nmo, input logic [15:0] ny
    );
        span_t       r;
        logic [63:0] then_abs;
        logic [63:0] now_abs;
        logic [63:0] years;
        logic [63:0] diff;
        r.seconds = '0;
        r.flag    = 1'b0;
        then_abs  = month_offset(tmo) + secs_into_month(ts, tm, th, td);
        if (ny < ty) begin
            r.flag = 1'b1;
        end else begin
            years = 64'(ny) - 64'(ty);
            if (years > 64'(MAX_YEAR_SPAN)) begin
                r.flag = 1'b1;
            end else begin
                now_abs = years * 64'd31536000 + month_offset(nmo) +
                          secs_into_month(ns, nm, nh, nd);
                if (now_abs < then_abs) begin
                    r.flag = 1'b1;
                end else begin
                    diff = now_abs - then_abs;
                    if (diff > 64'hFFFF_FFFF) begin
                        r.flag = 1'b1;
                    end else begin
                        r.seconds = diff[31:0];
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count    = 0;
        pending_spans = 0;
    end

    // Queue the prediction on each accepted item, then check any result strobe.
    always @(posedge i_clk) begin
        span_t want;
        if (i_rst_n && start && !busy) begin
            expected_spans.push_back(elapsed_between(
                i_then_second, i_then_minute, i_then_hour, i_then_day,
                i_then_month, i_then_year,
                i_now_second, i_now_minute, i_now_hour, i_now_day,
                i_now_month, i_now_year));
        end
        if (i_rst_n && o_done) begin
            if (expected_spans.size() == 0) begin
                report_mismatch("unexpected result, elapsed_seconds", o_elapsed_seconds, 0);
            end else begin
                want = expected_spans.pop_front();
                if (o_elapsed_seconds !== want.seconds) begin
                    report_mismatch("elapsed_seconds", o_elapsed_seconds, want.seconds);
                end
                if (o_span_error !== want.flag) begin
                    report_mismatch("span_error", o_span_error, want.flag);
                end
            end
        end
        pending_spans = expected_spans.size();
    end

endmodule

// ===== dv/calendar_time_difference_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar time difference testbench
// Drives timestamp pairs into the block in random bursts: first a directed
// set of calendar corners, then mostly well-formed random spans mixed with
// backwards, over-long and out-of-range items. The checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module calendar_time_difference_tb;
    import ctd_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } stamp_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    stamp_t      then_ts;
    stamp_t      now_ts;
    logic        o_done;
    logic [31:0] o_elapsed_seconds;
    logic        o_span_error;
    int          fail_count;
    int          pending_spans;
    int          idle_cycles;

    calendar_time_difference u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_then_second     (then_ts.second),
        .i_then_minute     (then_ts.minute),
        .i_then_hour       (then_ts.hour),
        .i_then_day        (then_ts.day),
        .i_then_month      (then_ts.month),
        .i_then_year       (then_ts.year),
        .i_now_second      (now_ts.second),
        .i_now_minute      (now_ts.minute),
        .i_now_hour        (now_ts.hour),
        .i_now_day         (now_ts.day),
        .i_now_month       (now_ts.month),
        .i_now_year        (now_ts.year),
        .o_done            (o_done),
        .o_elapsed_seconds (o_elapsed_seconds),
        .o_span_error      (o_span_error)
    );

    calendar_time_difference_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_then_second     (then_ts.second),
        .i_then_minute     (then_ts.minute),
        .i_then_hour       (then_ts.hour),
        .i_then_day        (then_ts.day),
        .i_then_month      (then_ts.month),
        .i_then_year       (then_ts.year),
        .i_now_second      (now_ts.second),
        .i_now_minute      (now_ts.minute),
        .i_now_hour        (now_ts.hour),
        .i_now_day         (now_ts.day),
        .i_now_month       (now_ts.month),
        .i_now_year        (now_ts.year),
        .o_done            (o_done),
        .o_elapsed_seconds (o_elapsed_seconds),
        .o_span_error      (o_span_error),
        .fail_count        (fail_count),
        .pending_spans     (pending_spans)
    );

    // Free-running 100 MHz clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The run ends if neither an item nor a result moves for too long.
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic stamp_t mk(
        input int unsigned s, input int unsigned mi, input int unsigned h,
        input int unsigned d, input int unsigned mo, input int unsigned y
    );
        stamp_t t;
        t.second = 6'(s);
        t.minute = 6'(mi);
        t.hour   = 5'(h);
        t.day    = 5'(d);
        t.month  = 4'(mo);
        t.year   = 16'(y);
        return t;
    endfunction

    // A time of day and date, either within range or with raw random bits.
    function automatic stamp_t random_stamp(input bit wild, input int unsigned y);
        stamp_t t;
        if (wild) begin
            t = stamp_t'({$urandom, $urandom});
        end else begin
            t = mk($urandom_range(0, 59), $urandom_range(0, 59), $urandom_range(0, 23),
                   $urandom_range(1, 31), $urandom_range(1, 12), 0);
        end
        t.year = 16'(y);
        return t;
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic send_item(input stamp_t t, input stamp_t n);
        then_ts <= t;
        now_ts  <= n;
        start   <= 1'b1;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop start for a gap of some cycles; a gap of zero keeps it high.
    task automatic pause(input int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Build one random pair, weighted toward spans that the block accepts.
    task automatic random_pair(output stamp_t t, output stamp_t n);
        int unsigned kind;
        int unsigned span;
        int unsigned ty;
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            // Forward span within the year limit.
            span = $urandom_range(0, MAX_YEAR_SPAN);
            ty   = $urandom_range(0, 65535 - span);
            t    = random_stamp(1'b0, ty);
            n    = random_stamp(1'b0, ty + span);
        end else if (kind < 75) begin
            // Same year and month: a plain difference, either order.
            ty = $urandom_range(0, 65535);
            t  = random_stamp(1'b0, ty);
            n  = random_stamp(1'b0, ty);
            n.month = t.month;
            if ($urandom_range(0, 3) == 0) begin
                n.day = t.day;
            end
        end else if (kind < 85) begin
            // Span right at the year limit or one past it.
            span = MAX_YEAR_SPAN + $urandom_range(0, 1);
            ty   = $urandom_range(0, 65535 - span);
            t    = random_stamp(1'b0, ty);
            n    = random_stamp(1'b0, ty + span);
        end else if (kind < 93) begin
            // Now lies in an earlier year than then.
            ty = $urandom_range(1, 65535);
            t  = random_stamp(1'($urandom_range(0, 1)), ty);
            n  = random_stamp(1'($urandom_range(0, 1)), $urandom_range(0, ty - 1));
        end else begin
            // Raw field bits: day zero, months past twelve, long hours and minutes.
            span = $urandom_range(0, MAX_YEAR_SPAN + 2);
            ty   = $urandom_range(0, 65535 - span);
            t    = random_stamp(1'b1, ty);
            n    = random_stamp(1'b1, ty + span);
        end
    endtask

    initial begin
        stamp_t t;
        stamp_t n;
        int     sent;
        int     burst;
        int     k;

        i_rst_n = 1'b0;
        start   = 1'b0;
        then_ts = '0;
        now_ts  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed corners of the calendar and the span checks.
        send_item(mk(0, 0, 0, 1, 1, 0), mk(0, 0, 0, 1, 1, 0));
        pause($urandom_range(0, 2));
        send_item(mk(30, 30, 12, 15, 6, 2000), mk(30, 30, 12, 15, 6, 2000));
        pause($urandom_range(0, 2));
        send_item(mk(10, 5, 3, 7, 4, 1999), mk(11, 5, 3, 7, 4, 1999));
        pause($urandom_range(0, 2));
        // Same month, now one second earlier.
        send_item(mk(11, 5, 3, 7, 4, 1999), mk(10, 5, 3, 7, 4, 1999));
        pause($urandom_range(0, 2));
        // Widest legal span.
        send_item(mk(0, 0, 0, 1, 1, 100), mk(59, 59, 23, 31, 12, 120));
        pause($urandom_range(0, 2));
        // One year past the limit.
        send_item(mk(0, 0, 0, 1, 1, 100), mk(0, 0, 0, 1, 1, 121));
        pause($urandom_range(0, 2));
        // Now in an earlier year.
        send_item(mk(0, 0, 0, 1, 1, 500), mk(59, 59, 23, 31, 12, 499));
        pause($urandom_range(0, 2));
        send_item(mk(59, 59, 23, 31, 12, 65535), mk(59, 59, 23, 31, 12, 65535));
        pause($urandom_range(0, 2));
        send_item(mk(0, 0, 0, 1, 1, 65515), mk(59, 59, 23, 31, 12, 65535));
        pause($urandom_range(0, 2));
        send_item(mk(0, 0, 0, 1, 1, 65535), mk(0, 0, 0, 1, 1, 0));
        pause($urandom_range(0, 2));
        // Day zero counts as the first of the month.
        send_item(mk(5, 0, 0, 0, 3, 42), mk(5, 0, 0, 1, 3, 42));
        pause($urandom_range(0, 2));
        send_item(mk(0, 0, 0, 0, 3, 42), mk(0, 0, 0, 0, 7, 42));
        pause($urandom_range(0, 2));
        // Month zero is January; thirteen to fifteen are December.
        send_item(mk(0, 0, 0, 1, 0, 7), mk(0, 0, 0, 1, 13, 7));
        pause($urandom_range(0, 2));
        send_item(mk(0, 0, 0, 1, 15, 7), mk(0, 0, 0, 1, 14, 8));
        pause($urandom_range(0, 2));
        // Time of day past its range is taken as given.
        send_item(mk(63, 63, 31, 31, 1, 9), mk(0, 0, 0, 1, 2, 9));
        pause($urandom_range(0, 2));
        send_item(mk(0, 0, 0, 31, 12, 9), mk(63, 63, 31, 31, 12, 9));
        pause($urandom_range(0, 2));
        // Later month but earlier second within the same year is fine; earlier month is not.
        send_item(mk(0, 0, 0, 1, 9, 300), mk(0, 0, 0, 1, 8, 300));
        pause($urandom_range(0, 2));
        send_item(mk(59, 59, 23, 31, 12, 300), mk(0, 0, 0, 1, 1, 301));
        pause($urandom_range(0, 2));
        send_item(mk(59, 59, 23, 28, 2, 300), mk(0, 0, 0, 1, 3, 300));
        pause($urandom_range(0, 2));
        send_item(mk(63, 63, 31, 31, 15, 1000), mk(0, 0, 0, 0, 0, 1020));
        pause($urandom_range(0, 2));
        send_item(mk(0, 0, 0, 1, 12, 1000), mk(0, 0, 0, 1, 1, 1020));
        pause($urandom_range(1, 3));

        // Random items in bursts with random gaps between them.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                random_pair(t, n);
                send_item(t, n);
                sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
                pause(0);
            end else begin
                pause($urandom_range(1, 15));
            end
        end
        start <= 1'b0;

        // Drain the outstanding results, then let the block settle.
        while (pending_spans != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
